// File: rtl/sdti_pkg.sv
// shared types and constants for the decimal text to int128 converter
// no dependencies; used by sdti_parse and saturating_decimal_to_int128_top
`default_nettype none

package sdti_pkg;

  localparam int unsigned MagW  = 128;
  localparam int unsigned CharW = 8;
  localparam int unsigned HalfW = 64;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;

  // parser hands a finished string to the result path
  typedef struct packed {
    logic            done;
    logic            neg;
    logic [MagW-1:0] mag;
  } parse_res_t;

endpackage

`default_nettype wire

// File: rtl/sdti_parse.sv
// byte-at-a-time decimal parser with saturating 128-bit magnitude
// depends on sdti_pkg
`default_nettype none

module sdti_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        take_i,
  input  wire logic [sdti_pkg::CharW-1:0]  char_code_i,
  input  wire logic                        is_last_i,
  input  wire logic                        end_only_i,
  output sdti_pkg::parse_res_t             res_o
);

  typedef enum logic [1:0] {
    PhSpace  = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhStop   = 2'd3
  } phase_e;

  localparam int unsigned ExtW = sdti_pkg::MagW + 3;

  phase_e                        phase_q, phase_d;
  logic                          neg_q, neg_d;
  logic [sdti_pkg::MagW-1:0]     mag_q, mag_d;

  logic                          is_digit, is_space, is_sign;
  logic [3:0]                    digit;
  logic [ExtW-1:0]               mag_ext, mag10;
  logic [sdti_pkg::MagW-1:0]     limit;
  logic [sdti_pkg::MagW-1:0]     mag_step;
  logic                          ends;

  always_comb begin
    is_digit = (char_code_i >= sdti_pkg::CharZero) && (char_code_i <= sdti_pkg::CharNine);
    is_space = (char_code_i == sdti_pkg::CharSpace) ||
               ((char_code_i >= sdti_pkg::CharTab) && (char_code_i <= sdti_pkg::CharCr));
    is_sign  = (char_code_i == sdti_pkg::CharPlus) || (char_code_i == sdti_pkg::CharMinus);
    digit    = 4'(char_code_i - sdti_pkg::CharZero);

    // times ten as shift-add, plus the new digit
    mag_ext  = {3'b000, mag_q};
    mag10    = (mag_ext << 3) + (mag_ext << 1) + {{(ExtW-4){1'b0}}, digit};
    limit    = neg_q ? {1'b1, {(sdti_pkg::MagW-1){1'b0}}}
                     : {1'b0, {(sdti_pkg::MagW-1){1'b1}}};
    mag_step = (mag10 > {3'b000, limit}) ? limit : mag10[sdti_pkg::MagW-1:0];
  end

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (!end_only_i) begin
      case (phase_q)
        PhSpace: begin
          if (is_space) begin
            phase_d = PhSpace;
          end else if (is_sign) begin
            neg_d   = (char_code_i == sdti_pkg::CharMinus);
            phase_d = PhSign;
          end else if (is_digit) begin
            mag_d   = mag_step;
            phase_d = PhDigits;
          end else begin
            phase_d = PhStop;
          end
        end
        PhSign, PhDigits: begin
          if (is_digit) begin
            mag_d   = mag_step;
            phase_d = PhDigits;
          end else begin
            phase_d = PhStop;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  assign ends = is_last_i || end_only_i;

  always_comb begin
    res_o.done = take_i && ends;
    res_o.neg  = neg_d;
    res_o.mag  = mag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSpace;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else if (take_i) begin
      if (ends) begin
        // string finished, back to the start for the next one
        phase_q <= PhSpace;
        neg_q   <= 1'b0;
        mag_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/saturating_decimal_to_int128_top.sv
// top level of the decimal text to signed 128-bit integer converter
// depends on sdti_pkg and sdti_parse
`default_nettype none

// Takes one text byte per cycle (leading whitespace, optional sign, decimal
// digits) and returns the saturated signed 128-bit value as two 64-bit
// halves on the transaction that ends the string. A new byte is accepted
// every cycle unless the input stalls; the multiply-by-ten shift-add and
// limit compare in the parser are combinational. The ending transaction's
// result is registered first as the parsed magnitude, then as the two's
// complement value in the output register. Input stalls only while a finished
// magnitude cannot move into a full, stalled output register.
module saturating_decimal_to_int128_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [sdti_pkg::CharW-1:0]        char_code_i,
  input  wire logic                              is_last_i,
  input  wire logic                              end_only_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic signed [sdti_pkg::HalfW-1:0] value_high_o,
  output      logic [sdti_pkg::HalfW-1:0]        value_low_o
);

  sdti_pkg::parse_res_t          res;
  logic                          take;

  logic                          a_valid_q;
  logic                          a_neg_q;
  logic [sdti_pkg::MagW-1:0]     a_mag_q;
  logic                          a_adv;

  logic                          out_valid_q;
  logic [sdti_pkg::MagW-1:0]     value_q, value_d;

  assign a_adv      = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !a_adv;
  assign take       = in_valid_i && !in_stall_o;

  sdti_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .end_only_i  (end_only_i),
    .res_o       (res)
  );

  // zero magnitude stays zero when negated, so no digit flag is needed
  assign value_d = a_neg_q ? (~a_mag_q + {{(sdti_pkg::MagW-1){1'b0}}, 1'b1}) : a_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (res.done) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      a_neg_q <= res.neg;
      a_mag_q <= res.mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_high_o = signed'(value_q[sdti_pkg::MagW-1:sdti_pkg::HalfW]);
  assign value_low_o  = value_q[sdti_pkg::HalfW-1:0];

endmodule

`default_nettype wire

// File: test/tb_saturating_decimal_to_int128_top.sv
// testbench for saturating_decimal_to_int128_top: streams text bytes, predicts the int128 value
// depends on sdti_pkg and the rtl top level; checks each result against an in-order prediction
`timescale 1ns / 100ps

module tb_saturating_decimal_to_int128_top;

  localparam int    CycleLimit = 200000;
  localparam int    RandomItems = 900;
  localparam string MaxText = "170141183460469231731687303715884105727";
  localparam string MinText = "170141183460469231731687303715884105728";

  typedef enum logic [1:0] {PhSpace, PhSign, PhDigits, PhStop} parse_phase_e;

  typedef struct packed {
    logic [sdti_pkg::CharW-1:0] code;
    logic                       last;
    logic                       eo;
    logic                       hold;
  } text_item_t;

  typedef struct packed {
    logic signed [sdti_pkg::HalfW-1:0] hi;
    logic [sdti_pkg::HalfW-1:0]        lo;
  } int128_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [sdti_pkg::CharW-1:0]        char_code = '0;
  logic                              is_last = 1'b0;
  logic                              end_only = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [sdti_pkg::HalfW-1:0] value_high;
  logic [sdti_pkg::HalfW-1:0]        value_low;

  text_item_t text_q[$];
  int128_t    value_q[$];
  int128_t    want;
  int128_t    got_val;
  int         errors = 0;
  int         cyc_cnt = 0;
  int         items_made = 0;
  bit         next_hold = 1'b0;
  logic       calm;

  // parser state mirrored in the testbench
  parse_phase_e              parse_st = PhSpace;
  logic                      neg = 1'b0;
  logic                      seen = 1'b0;
  logic [sdti_pkg::MagW-1:0] mag = '0;

  saturating_decimal_to_int128_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_code_i  (char_code),
    .is_last_i    (is_last),
    .end_only_i   (end_only),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_high_o (value_high),
    .value_low_o  (value_low)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // no random idling and no output stalls inside this window
  assign calm = (cyc_cnt >= 300) && (cyc_cnt < 700);

  // magnitude*10 + d, clamped at 2^127-1 or 2^127 depending on sign
  function automatic void add_digit(input logic [3:0] d);
    logic [sdti_pkg::MagW+3:0] prod;
    logic [sdti_pkg::MagW-1:0] lim;
    lim  = neg ? {1'b1, {(sdti_pkg::MagW-1){1'b0}}} : {1'b0, {(sdti_pkg::MagW-1){1'b1}}};
    prod = {4'b0, mag} * (sdti_pkg::MagW+4)'(10) + (sdti_pkg::MagW+4)'(d);
    if (prod > {4'b0, lim}) mag = lim;
    else mag = prod[sdti_pkg::MagW-1:0];
    seen = 1'b1;
    parse_st = PhDigits;
  endfunction

  function automatic void take_char(input logic [sdti_pkg::CharW-1:0] c);
    logic is_dig;
    is_dig = (c >= sdti_pkg::CharZero) && (c <= sdti_pkg::CharNine);
    case (parse_st)
      PhSpace: begin
        if (c == sdti_pkg::CharSpace ||
            (c >= sdti_pkg::CharTab && c <= sdti_pkg::CharCr)) parse_st = PhSpace;
        else if (c == sdti_pkg::CharPlus || c == sdti_pkg::CharMinus) begin
          neg = (c == sdti_pkg::CharMinus);
          parse_st = PhSign;
        end else if (is_dig) add_digit(4'(c - sdti_pkg::CharZero));
        else parse_st = PhStop;
      end
      PhSign, PhDigits: begin
        if (is_dig) add_digit(4'(c - sdti_pkg::CharZero));
        else parse_st = PhStop;
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the transaction ends a string, with the signed value in val
  function automatic bit convert_step(input text_item_t it, output int128_t val);
    logic [sdti_pkg::MagW-1:0] v;
    val = '0;
    if (!it.eo) take_char(it.code);
    if (!it.last && !it.eo) return 1'b0;
    v = seen ? (neg ? -mag : mag) : '0;
    val.hi = v[sdti_pkg::MagW-1:sdti_pkg::HalfW];
    val.lo = v[sdti_pkg::HalfW-1:0];
    parse_st = PhSpace;
    neg = 1'b0;
    seen = 1'b0;
    mag = '0;
    return 1'b1;
  endfunction

  task automatic add_item(input logic [sdti_pkg::CharW-1:0] c, input logic last,
                          input logic eo);
    text_item_t it;
    it.code = c;
    it.last = last;
    it.eo = eo;
    it.hold = next_hold;
    next_hold = 1'b0;
    text_q.insert(text_q.size(), it);
    items_made++;
  endtask

  function automatic logic [sdti_pkg::CharW-1:0] rand_digit();
    return sdti_pkg::CharZero + sdti_pkg::CharW'($urandom_range(0, 9));
  endfunction

  function automatic logic [sdti_pkg::CharW-1:0] rand_space();
    return ($urandom_range(0, 5) == 0) ? sdti_pkg::CharSpace
                                       : sdti_pkg::CharW'($urandom_range(9, 13));
  endfunction

  function automatic logic [sdti_pkg::CharW-1:0] rand_noise();
    case ($urandom_range(0, 3))
      0: return rand_space();
      1: return $urandom_range(0, 1) ? sdti_pkg::CharMinus : sdti_pkg::CharPlus;
      2: return rand_digit();
      default: return sdti_pkg::CharW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_string();
    logic [sdti_pkg::CharW-1:0] body[$];
    string num;
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(0, 3)) body.insert(body.size(), rand_space());
      if ($urandom_range(0, 2) != 0)
        body.insert(body.size(),
                    $urandom_range(0, 1) ? sdti_pkg::CharMinus : sdti_pkg::CharPlus);
      n = $urandom_range(0, 99);
      if (n < 12) begin
        // digits of the limits with the tail disturbed
        num = $urandom_range(0, 1) ? MaxText : MinText;
        for (int k = 0; k < 3; k++)
          if ($urandom_range(0, 1)) num.putc(38 - k, rand_digit());
        for (int k = 0; k < num.len(); k++) body.insert(body.size(), num.getc(k));
        if ($urandom_range(0, 4) == 0) body.insert(body.size(), rand_digit());
      end else if (n < 22) begin
        repeat ($urandom_range(38, 45)) body.insert(body.size(), rand_digit());
      end else begin
        repeat ($urandom_range(1, 20)) body.insert(body.size(), rand_digit());
      end
    end else begin
      repeat ($urandom_range(1, 6)) body.insert(body.size(), rand_noise());
    end
    pick = $urandom_range(0, 99);
    if (pick >= 75 || body.size() == 0) begin
      foreach (body[i]) add_item(body[i], 1'b0, 1'b0);
      add_item(sdti_pkg::CharW'($urandom_range(0, 255)), 1'(($urandom_range(0, 1))), 1'b1);
    end else begin
      if (pick >= 50)
        repeat ($urandom_range(1, 3))
          body.insert(body.size(), sdti_pkg::CharW'($urandom_range(0, 255)));
      foreach (body[i]) add_item(body[i], 1'(i == body.size() - 1), 1'b0);
    end
  endtask

  // driver: presents the head of text_q, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      char_code <= '0;
      is_last <= 1'b0;
      end_only <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (convert_step(text_q[0], got_val)) value_q.insert(value_q.size(), got_val);
        void'(text_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (text_q.size() == 0 || (!calm && $urandom_range(0, 99) < 8) ||
            (text_q[0].hold && value_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          char_code <= text_q[0].code;
          is_last <= text_q[0].last;
          end_only <= text_q[0].eo;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest predicted value
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (value_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h %h",
                   $time, value_high, value_low);
          errors++;
        end else begin
          want = value_q.pop_front();
          if (value_high !== want.hi) begin
            $display("%0t: value_high expected %h got %h", $time, want.hi, value_high);
            errors++;
          end
          if (value_low !== want.lo) begin
            $display("%0t: value_low expected %h got %h", $time, want.lo, value_low);
            errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  initial begin
    while (cyc_cnt < CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    // empty string
    add_item(8'hA5, 1'b0, 1'b1);
    // minus zero
    add_item(sdti_pkg::CharMinus, 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero, 1'b1, 1'b0);
    // every whitespace byte, then one digit
    for (int c = 9; c <= 13; c++) add_item(sdti_pkg::CharW'(c), 1'b0, 1'b0);
    add_item(sdti_pkg::CharSpace, 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero + 8'd5, 1'b1, 1'b0);
    // second sign stops with no digits
    add_item(sdti_pkg::CharPlus, 1'b0, 1'b0);
    add_item(sdti_pkg::CharMinus, 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero + 8'd3, 1'b0, 1'b0);
    add_item(8'hFF, 1'b1, 1'b1);
    // stray byte after digits, sent only once the pipeline has drained
    next_hold = 1'b1;
    add_item(sdti_pkg::CharNine, 1'b0, 1'b0);
    add_item("x", 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero + 8'd8, 1'b1, 1'b0);
    // both end bits set: the byte is not taken
    add_item(sdti_pkg::CharZero + 8'd4, 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero + 8'd7, 1'b1, 1'b1);
    // nul byte alone
    add_item(8'h00, 1'b1, 1'b0);
    // negative value closed by a byte of all ones
    add_item(sdti_pkg::CharMinus, 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero + 8'd1, 1'b0, 1'b0);
    add_item(sdti_pkg::CharZero + 8'd2, 1'b0, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);

    items_made = 0;
    for (int s = 0; items_made < RandomItems; s++) begin
      if (s % 60 == 59) next_hold = 1'b1;
      add_random_string();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0) @(posedge clk_i);
    while (value_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
